### design/ata_pkg.sv
// ata_pkg: shared types, codes and default sizes for the ASID table allocator.
// No dependencies; used by asid_table_allocator_core.
package ata_pkg;

   localparam int NUM_IDS_DEF    = 256;
   localparam int OWNER_BITS_DEF = 16;

   localparam int ID_FIELD_W    = 8;
   localparam int OWNER_FIELD_W = 16;
   localparam int STATUS_W      = 2;

   // request codes
   localparam logic REQ_ALLOC     = 1'b0;
   localparam logic REQ_SET_VALID = 1'b1;

   // policy register codes
   localparam logic POLICY_RR     = 1'b0;
   localparam logic POLICY_STATIC = 1'b1;

   // table entry codes
   localparam logic [1:0] ENT_INVALID = 2'd0;
   localparam logic [1:0] ENT_FREE    = 2'd1;
   localparam logic [1:0] ENT_OWNED   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] RSP_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NONE      = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_RANGE_OK  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RANGE,
      ST_SCAN
   } state_type;

endpackage

### design/asid_table_allocator_core.sv
// asid_table_allocator_core: ASID table with round-robin / static allocation.
// Depends on ata_pkg; holds the entry status and owner memories.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+------------------------------
//   request | req_type, req_owner_space, req_current_id,
//           | req_range_first, req_range_last        | start & !busy
//   result  | rsp_status, rsp_granted_id, rsp_evicted,
//           | rsp_evicted_owner                      | rsp_strobe, one cycle, no stall
//   config  | csr_policy_mode                        | csr_write_en
//
// Allocate: one status-memory read per cycle from the scan pointer, up to NUM_IDS reads;
// the result beat follows the cycle that finds or gives up.
// Set-valid: one read-modify-write per entry of the range; an empty range is answered from idle.
// Reset starts a clearing pass over all NUM_IDS status-memory entries, busy held high.
// One request at a time; busy is low only in idle. Result beats are never stalled.
module asid_table_allocator_core #(
   parameter int NUM_IDS    = ata_pkg::NUM_IDS_DEF,
   parameter int OWNER_BITS = ata_pkg::OWNER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic                              csr_policy_mode,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [ata_pkg::OWNER_FIELD_W-1:0] req_owner_space,
   input  logic [ata_pkg::ID_FIELD_W-1:0]    req_current_id,
   input  logic [ata_pkg::ID_FIELD_W-1:0]    req_range_first,
   input  logic [ata_pkg::ID_FIELD_W-1:0]    req_range_last,
   output logic                              rsp_strobe,
   output logic [ata_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ata_pkg::ID_FIELD_W-1:0]    rsp_granted_id,
   output logic                              rsp_evicted,
   output logic [ata_pkg::OWNER_FIELD_W-1:0] rsp_evicted_owner
);

   localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IDS - 1);

   // memories
   logic [1:0]            status_mem [NUM_IDS];
   logic [OWNER_BITS-1:0] owner_mem  [NUM_IDS];

   ata_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]      end_ff, end_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [ata_pkg::ID_FIELD_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0]      scan_ptr_ff, scan_ptr_in;
   logic                  mode_ff, mode_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ata_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ata_pkg::ID_FIELD_W-1:0]    rsp_gid_ff, rsp_gid_in;
   logic                              rsp_evicted_ff, rsp_evicted_in;
   logic [ata_pkg::OWNER_FIELD_W-1:0] rsp_owner_ff, rsp_owner_in;

   logic [1:0]            st_rd_ff;
   logic [OWNER_BITS-1:0] own_rd_ff;

   logic                  st_we;
   logic [IDX_W-1:0]      st_wa;
   logic [1:0]            st_wd;
   logic                  own_we;

   logic                  accept;
   logic                  range_nonempty;
   logic [IDX_W-1:0]      range_end;
   logic                  cur_match;
   logic                  hit;
   logic [IDX_W-1:0]      addr_next;
   logic [IDX_W-1:0]      pend_next;

   assign accept = start && (state_ff == ata_pkg::ST_IDLE);
   assign busy   = (state_ff != ata_pkg::ST_IDLE);

   assign range_nonempty = (req_range_first <= req_range_last)
                           && (32'(req_range_first) < NUM_IDS);
   assign range_end = (32'(req_range_last) >= NUM_IDS) ? LAST_IDX
                                                         : IDX_W'(req_range_last);

   assign addr_next = (addr_ff == LAST_IDX) ? '0 : addr_ff + IDX_W'(1);
   assign pend_next = (pend_addr_ff == LAST_IDX) ? '0 : pend_addr_ff + IDX_W'(1);

   assign cur_match = (32'(pend_addr_ff) == 32'(cur_ff));
   assign hit = pend_ff && ((mode_ff == ata_pkg::POLICY_RR)
                            ? ((st_rd_ff != ata_pkg::ENT_INVALID) && !cur_match)
                            : (st_rd_ff == ata_pkg::ENT_FREE));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ata_pkg::ST_CLEAR: begin
            if (addr_ff == LAST_IDX) state_in = ata_pkg::ST_IDLE;
         end
         ata_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == ata_pkg::REQ_ALLOC) state_in = ata_pkg::ST_SCAN;
               else if (range_nonempty) state_in = ata_pkg::ST_RANGE;
            end
         end
         ata_pkg::ST_RANGE: begin
            if (!issue_ff && !pend_ff) state_in = ata_pkg::ST_IDLE;
         end
         ata_pkg::ST_SCAN: begin
            if (hit || (!issue_ff && !pend_ff)) state_in = ata_pkg::ST_IDLE;
         end
         default: state_in = ata_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      end_in       = end_ff;
      owner_in     = owner_ff;
      cur_in       = cur_ff;
      scan_ptr_in  = scan_ptr_ff;
      mode_in      = csr_write_en ? csr_policy_mode : mode_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_gid_in     = rsp_gid_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_owner_in   = rsp_owner_ff;
      st_we  = 1'b0;
      st_wa  = pend_addr_ff;
      st_wd  = ata_pkg::ENT_FREE;
      own_we = 1'b0;

      unique case (state_ff)
         ata_pkg::ST_CLEAR: begin
            st_we   = 1'b1;
            st_wa   = addr_ff;
            st_wd   = ata_pkg::ENT_INVALID;
            addr_in = addr_next;
         end
         ata_pkg::ST_IDLE: begin
            if (accept) begin
               owner_in = OWNER_BITS'(req_owner_space);
               cur_in   = req_current_id;
               issue_in = 1'b1;
               cnt_in   = '0;
               if (req_type == ata_pkg::REQ_ALLOC) begin
                  addr_in = scan_ptr_ff;
               end else begin
                  addr_in = IDX_W'(req_range_first);
                  end_in  = range_end;
                  if (!range_nonempty) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = ata_pkg::RSP_RANGE_OK;
                     rsp_gid_in     = '0;
                     rsp_evicted_in = 1'b0;
                     rsp_owner_in   = '0;
                  end
               end
            end
         end
         ata_pkg::ST_RANGE: begin
            if (issue_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
               addr_in      = addr_next;
               if (addr_ff == end_ff) issue_in = 1'b0;
            end
            if (pend_ff && (st_rd_ff == ata_pkg::ENT_INVALID)) st_we = 1'b1;
            if (!issue_ff && !pend_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ata_pkg::RSP_RANGE_OK;
               rsp_gid_in     = '0;
               rsp_evicted_in = 1'b0;
               rsp_owner_in   = '0;
            end
         end
         ata_pkg::ST_SCAN: begin
            if (hit) begin
               st_we          = 1'b1;
               st_wd          = ata_pkg::ENT_OWNED;
               own_we         = 1'b1;
               issue_in       = 1'b0;
               scan_ptr_in    = pend_next;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ata_pkg::RSP_ALLOCATED;
               rsp_gid_in     = ata_pkg::ID_FIELD_W'(pend_addr_ff);
               rsp_evicted_in = (st_rd_ff == ata_pkg::ENT_OWNED);
               rsp_owner_in   = (st_rd_ff == ata_pkg::ENT_OWNED)
                                ? ata_pkg::OWNER_FIELD_W'(own_rd_ff) : '0;
            end else begin
               if (issue_ff) begin
                  pend_in      = 1'b1;
                  pend_addr_in = addr_ff;
                  addr_in      = addr_next;
                  cnt_in       = cnt_ff + IDX_W'(1);
                  if (cnt_ff == LAST_IDX) issue_in = 1'b0;
               end
               if (!issue_ff && !pend_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ata_pkg::RSP_NONE;
                  rsp_gid_in     = '0;
                  rsp_evicted_in = 1'b0;
                  rsp_owner_in   = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ata_pkg::ST_CLEAR;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         scan_ptr_ff  <= '0;
         mode_ff      <= ata_pkg::POLICY_RR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         scan_ptr_ff  <= scan_ptr_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      pend_addr_ff   <= pend_addr_in;
      end_ff         <= end_in;
      owner_ff       <= owner_in;
      cur_ff         <= cur_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_gid_ff     <= rsp_gid_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_owner_ff   <= rsp_owner_in;
   end

   // status and owner memories, registered read
   always_ff @(posedge clock) begin
      if (st_we) status_mem[st_wa] <= st_wd;
      st_rd_ff <= status_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (own_we) owner_mem[pend_addr_ff] <= owner_ff;
      own_rd_ff <= owner_mem[addr_ff];
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_id    = rsp_gid_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_evicted_owner = rsp_owner_ff;

`ifndef SYNTHESIS
   a_alloc_from_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ata_pkg::RSP_ALLOCATED))
      |-> $past(state_ff == ata_pkg::ST_SCAN))
      else $error("allocated beat not preceded by a scan");

   a_evict_only_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |-> (rsp_status_ff == ata_pkg::RSP_ALLOCATED))
      else $error("eviction reported on a non-allocation beat");

   a_ptr_moves_on_grant: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (scan_ptr_ff != $past(scan_ptr_ff)))
      |-> (rsp_valid_ff && (rsp_status_ff == ata_pkg::RSP_ALLOCATED)))
      else $error("scan pointer moved without a grant");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ($past(state_ff == ata_pkg::ST_SCAN)
                   || $past(state_ff == ata_pkg::ST_RANGE)))
      else $error("memory read in flight outside a walk");
`endif

endmodule
